// File: src/tqs_pkg.sv
// ============================================================================
// tqs_pkg
// Shared types, codes and helpers for the tone queue sequencer.
// ============================================================================
`default_nettype none

package tqs_pkg;

    // stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEPER_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEAKER_PITCH = 1'd1;

    // item kinds
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_PLAY_NOW    = 2'd1;
    localparam logic [1:0] OP_PLAY_QUEUED = 2'd2;

    // beeper modes
    localparam logic [2:0] MODE_QUIET    = 3'd0;
    localparam logic [2:0] MODE_SHORT    = 3'd2;
    localparam logic [2:0] MODE_ONE_HALF = 3'd3;
    localparam logic [2:0] MODE_NORMAL   = 3'd4;
    localparam logic [2:0] MODE_LONG     = 3'd5;
    localparam logic [2:0] MODE_XLONG    = 3'd6;

    // speaker follows the top bit of the phase accumulator
    localparam int PHASE_MSB = 7;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        freq;
        logic [7:0]        length;
        logic [7:0]        pause;
        logic [7:0]        rpt;
        logic signed [7:0] freq_step;
    } t_in_item;

    // one queue slot, freq in the low byte
    typedef struct packed {
        logic [7:0] step;
        logic [7:0] rpt;
        logic [7:0] pause;
        logic [7:0] length;
        logic [7:0] freq;
    } t_entry;

    function automatic logic [7:0] scale_length(input logic [2:0] mode,
                                                input logic [7:0] len);
        logic [9:0] triple;
        logic [7:0] res;
        triple = {2'b00, len} + {1'b0, len, 1'b0};
        case (mode)
            MODE_SHORT:    res = {1'b0, len[7:1]};
            MODE_ONE_HALF: res = triple[8:1];
            MODE_LONG:     res = {len[6:0], 1'b0};
            MODE_XLONG:    res = triple[7:0];
            default:       res = len;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/tqs_queue_ram.sv
// ============================================================================
// tqs_queue_ram
// Tone queue storage: one write port, one registered read port.
// ============================================================================
`default_nettype none

module tqs_queue_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire                   i_clk,
    input  wire                   i_wr_en,
    input  wire  [ADDR_W-1:0]     i_wr_addr,
    input  tqs_pkg::t_entry       i_wr_data,
    input  wire                   i_rd_en,
    input  wire  [ADDR_W-1:0]     i_rd_addr,
    output tqs_pkg::t_entry       o_rd_data
);
    import tqs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/tone_queue_sequencer_core.sv
// ============================================================================
// tone_queue_sequencer_core
// Buzzer tone sequencer with a request queue held in a small memory.
// ============================================================================
// Usage:
//   s_axis carries one item per beat: tuser is the kind (tick, play now,
//   play queued), tdata the tone request fields. m_axis returns one result
//   beat per input beat, in order: speaker level, busy, current frequency
//   and the drop flag for a queued request that found the queue full.
//   The config port writes beeper mode and speaker pitch; write only while
//   no beat is in flight.
//   An accepted beat reads the queue head at the accepting edge and does
//   the read-modify-write of all state in its update cycle, once the output
//   register is free; its result is loaded into the output register there.
//   A new beat is taken only once the last one has been updated; the split
//   into head read and update comes from the registered queue memory read.
//   The output register lets the next beat enter while a result waits; if
//   the receiver keeps tready low the second beat waits in its update cycle
//   and s_axis_tready stays low until the result can be stored.
//   Reset is synchronous; the queue memory needs no clearing pass since an
//   entry is read only after it was written.
// ============================================================================
`default_nettype none

module tone_queue_sequencer_core #(
    parameter int QUEUE_DEPTH              = 8,
    parameter int TICKS_PER_STEP_MINUS_ONE = 77,
    parameter int PITCH_OFFSET             = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [tqs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [tqs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // freq, length, pause, repeat_req, freq_step
    input  wire  [tqs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  wire  [tqs_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // speaker, busy_res, current_freq, dropped, zero fill
    output logic [tqs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import tqs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int PRE_W = $clog2(TICKS_PER_STEP_MINUS_ONE + 1);

    localparam logic [7:0]       PITCH_OFF  = 8'(PITCH_OFFSET);
    localparam logic [PRE_W-1:0] PRE_RELOAD = PRE_W'(TICKS_PER_STEP_MINUS_ONE);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH  = SUM_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                    r_state;
    t_in_item                r_item;
    logic [2:0]              r_mode;
    logic [7:0]              r_pitch;
    logic [7:0]              r_phase,     n_phase;
    logic [PRE_W-1:0]        r_prescale,  n_prescale;
    logic [7:0]              r_time_left, n_time_left;
    logic [7:0]              r_tone_freq, n_tone_freq;
    logic [7:0]              r_tone_step, n_tone_step;
    logic [7:0]              r_pause_left, n_pause_left;
    logic                    r_level,     n_level;
    logic [PTR_W-1:0]        r_read_ptr,  n_read_ptr;
    logic [CNT_W-1:0]        r_count,     n_count;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic                    w_accept;
    logic                    w_done;
    logic                    w_dropped;
    logic                    w_wr_req;
    logic [PTR_W-1:0]        w_wr_addr;
    t_entry                  w_wr_data;
    t_entry                  w_head;
    t_entry                  w_req;
    logic [SUM_W-1:0]        w_tail_sum;
    logic [PTR_W-1:0]        w_tail;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // head is read on acceptance, written back only in the update cycle,
    // so a read never meets a write to the same slot in one cycle
    tqs_queue_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_req && w_done),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_read_ptr),
        .o_rd_data (w_head)
    );

    // tail slot, read_ptr + count folded once into the ring
    assign w_tail_sum = {1'b0, r_read_ptr} + SUM_W'(r_count);
    assign w_tail     = (w_tail_sum >= SUM_DEPTH) ? PTR_W'(w_tail_sum - SUM_DEPTH)
                                                  : PTR_W'(w_tail_sum);

    always_comb begin
        w_req.freq   = r_item.freq + r_pitch + PITCH_OFF;
        w_req.length = scale_length(r_mode, r_item.length);
        w_req.pause  = r_item.pause;
        w_req.rpt    = r_item.rpt;
        w_req.step   = r_item.freq_step;
    end

    always_comb begin
        n_phase      = r_phase;
        n_prescale   = r_prescale;
        n_time_left  = r_time_left;
        n_tone_freq  = r_tone_freq;
        n_tone_step  = r_tone_step;
        n_pause_left = r_pause_left;
        n_level      = r_level;
        n_read_ptr   = r_read_ptr;
        n_count      = r_count;
        w_dropped    = 1'b0;
        w_wr_req     = 1'b0;
        w_wr_addr    = w_tail;
        w_wr_data    = w_req;
        case (r_item.op)
            OP_TICK: begin
                if (r_time_left != 8'd0) begin
                    n_phase = r_phase + r_tone_freq;
                    n_level = n_phase[PHASE_MSB];
                end
                if (r_prescale == '0) begin
                    n_prescale = PRE_RELOAD;
                    if (r_time_left != 8'd0) begin
                        n_time_left = r_time_left - 8'd1;
                        n_tone_freq = r_tone_freq + r_tone_step;
                    end else begin
                        n_level = 1'b0;
                        if (r_pause_left != 8'd0) begin
                            n_pause_left = r_pause_left - 8'd1;
                        end else if (r_count != '0) begin
                            n_tone_freq  = w_head.freq;
                            n_time_left  = w_head.length;
                            n_tone_step  = w_head.step;
                            n_pause_left = w_head.pause;
                            if (w_head.rpt == 8'd0) begin
                                n_read_ptr = (r_read_ptr == PTR_LAST) ? '0
                                                                      : r_read_ptr + 1'b1;
                                n_count    = r_count - 1'b1;
                            end else begin
                                // spend one repeat, slot stays at the head
                                w_wr_req      = 1'b1;
                                w_wr_addr     = r_read_ptr;
                                w_wr_data     = w_head;
                                w_wr_data.rpt = w_head.rpt - 8'd1;
                            end
                        end
                    end
                end else begin
                    n_prescale = r_prescale - 1'b1;
                end
            end
            OP_PLAY_NOW: begin
                if (r_mode != MODE_QUIET) begin
                    n_tone_freq  = w_req.freq;
                    n_time_left  = w_req.length;
                    n_pause_left = w_req.pause;
                    n_tone_step  = w_req.step;
                    n_count      = '0;
                    if (r_item.rpt != 8'd0) begin
                        w_wr_req      = 1'b1;
                        w_wr_addr     = r_read_ptr;
                        w_wr_data.rpt = r_item.rpt - 8'd1;
                        n_count       = CNT_W'(1);
                    end
                end
            end
            OP_PLAY_QUEUED: begin
                if (r_mode != MODE_QUIET) begin
                    if (r_count == CNT_FULL) begin
                        w_dropped = 1'b1;
                    end else begin
                        w_wr_req = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_NORMAL;
            r_pitch      <= 8'd0;
            r_phase      <= 8'd0;
            r_prescale   <= PRE_RELOAD;
            r_time_left  <= 8'd0;
            r_tone_freq  <= 8'd0;
            r_tone_step  <= 8'd0;
            r_pause_left <= 8'd0;
            r_level      <= 1'b0;
            r_read_ptr   <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_BEEPER_MODE:   r_mode  <= i_cfg_wdata[2:0];
                    REG_SPEAKER_PITCH: r_pitch <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_done) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_prescale   <= n_prescale;
                r_time_left  <= n_time_left;
                r_tone_freq  <= n_tone_freq;
                r_tone_step  <= n_tone_step;
                r_pause_left <= n_pause_left;
                r_level      <= n_level;
                r_read_ptr   <= n_read_ptr;
                r_count      <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op        <= s_axis_tuser[1:0];
            r_item.freq      <= s_axis_tdata[7:0];
            r_item.length    <= s_axis_tdata[15:8];
            r_item.pause     <= s_axis_tdata[23:16];
            r_item.rpt       <= s_axis_tdata[31:24];
            r_item.freq_step <= s_axis_tdata[39:32];
        end
        if (w_done) begin
            r_out_data <= {5'b00000, w_dropped, n_tone_freq,
                           (n_time_left != 8'd0), n_level};
        end
    end

endmodule

`default_nettype wire

// File: src/tqs_port_checker.sv
// ============================================================================
// tqs_port_checker
// Port-level checks of the tone queue sequencer, bound to the top level.
// ============================================================================
`default_nettype none

module tqs_port_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [tqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tqs_pkg::*;

    // a result beat held back stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one beat in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted during update");

    // with a free output register the result shows right after the head read and the update
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
        |=> ##1 m_axis_tvalid)
        else $error("result beat late");

    // input side reopens once the result is stored
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
        |=> ##1 s_axis_tready)
        else $error("input side did not reopen");

endmodule

bind tone_queue_sequencer_core tqs_port_checker u_tqs_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for tone_queue_sequencer_core. Beats go in on s_axis
// and are predicted one by one by a behavioral copy of the sequencer; every
// output beat is checked field by field against the oldest prediction.
// Directed cases cover field extremes, length scaling, quiet mode and the
// full queue. Random traffic follows under several register settings and
// idle patterns, and one long output stall fills the block up.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tqs_pkg::*;

    localparam int QUEUE_DEPTH   = 8;
    localparam int TICK_RELOAD   = 77;
    localparam int PITCH_OFFSET  = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [2:0] MODE_NO_KEYS = 3'd1;
    localparam logic [2:0] MODE_SEVEN   = 3'd7;

    typedef struct packed {
        logic       speaker;
        logic       busy;
        logic [7:0] freq;
        logic       dropped;
    } t_tone_status;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // freq, length, pause, repeat_req, freq_step
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // op
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // speaker, busy_res, current_freq, dropped, zero fill
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    tone_queue_sequencer_core #(
        .QUEUE_DEPTH             (QUEUE_DEPTH),
        .TICKS_PER_STEP_MINUS_ONE(TICK_RELOAD),
        .PITCH_OFFSET            (PITCH_OFFSET)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // sequencer prediction
    // ------------------------------------------------------------------------
    logic [2:0]   beeper_mode_q;
    logic [7:0]   speaker_pitch_q;
    logic [7:0]   phase_acc_m;
    int           prescale_m;
    logic [7:0]   time_left_m;
    logic [7:0]   tone_freq_m;
    logic [7:0]   tone_step_m;
    logic [7:0]   pause_left_m;
    logic         speaker_m;
    t_entry       tone_slots_m [QUEUE_DEPTH];
    int           rd_ptr_m;
    int           count_m;
    t_tone_status expected_status [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_request  = 0;
    int stall_left     = 0;
    int fail_count     = 0;

    function automatic void reset_sequencer();
        beeper_mode_q   = MODE_NORMAL;
        speaker_pitch_q = 8'd0;
        phase_acc_m     = 8'd0;
        prescale_m      = TICK_RELOAD;
        time_left_m     = 8'd0;
        tone_freq_m     = 8'd0;
        tone_step_m     = 8'd0;
        pause_left_m    = 8'd0;
        speaker_m       = 1'b0;
        rd_ptr_m        = 0;
        count_m         = 0;
    endfunction

    function automatic logic [7:0] scaled_len(input logic [7:0] len);
        int v;
        v = len;
        case (beeper_mode_q)
            MODE_SHORT:    v = v / 2;
            MODE_ONE_HALF: v = (v * 3) / 2;
            MODE_LONG:     v = v * 2;
            MODE_XLONG:    v = v * 3;
            default:       ;
        endcase
        return v[7:0];
    endfunction

    function automatic logic [7:0] pitched_freq(input logic [7:0] f);
        return f + speaker_pitch_q + 8'(PITCH_OFFSET);
    endfunction

    // returns 1 when the queue had no room
    function automatic logic queue_tone(input t_in_item it, input logic [7:0] rpt);
        int slot;
        if (count_m >= QUEUE_DEPTH)
            return 1'b1;
        slot = (rd_ptr_m + count_m) % QUEUE_DEPTH;
        tone_slots_m[slot].freq   = pitched_freq(it.freq);
        tone_slots_m[slot].length = scaled_len(it.length);
        tone_slots_m[slot].pause  = it.pause;
        tone_slots_m[slot].rpt    = rpt;
        tone_slots_m[slot].step   = it.freq_step;
        count_m++;
        return 1'b0;
    endfunction

    function automatic void step_tone();
        if (time_left_m != 8'd0) begin
            time_left_m = time_left_m - 8'd1;
            tone_freq_m = tone_freq_m + tone_step_m;
            return;
        end
        speaker_m = 1'b0;
        if (pause_left_m != 8'd0) begin
            pause_left_m = pause_left_m - 8'd1;
            return;
        end
        if (count_m > 0) begin
            tone_freq_m  = tone_slots_m[rd_ptr_m].freq;
            time_left_m  = tone_slots_m[rd_ptr_m].length;
            tone_step_m  = tone_slots_m[rd_ptr_m].step;
            pause_left_m = tone_slots_m[rd_ptr_m].pause;
            // head stays until its repeats are used up
            if (tone_slots_m[rd_ptr_m].rpt == 8'd0) begin
                rd_ptr_m = (rd_ptr_m + 1) % QUEUE_DEPTH;
                count_m--;
            end else begin
                tone_slots_m[rd_ptr_m].rpt = tone_slots_m[rd_ptr_m].rpt - 8'd1;
            end
        end
    endfunction

    function automatic void tick_tone();
        if (time_left_m != 8'd0) begin
            phase_acc_m = phase_acc_m + tone_freq_m;
            speaker_m   = phase_acc_m[7];
        end
        if (prescale_m == 0) begin
            prescale_m = TICK_RELOAD;
            step_tone();
        end else begin
            prescale_m--;
        end
    endfunction

    function automatic void predict_beat(input t_in_item it);
        logic         dropped;
        t_tone_status st;
        dropped = 1'b0;
        case (it.op)
            OP_TICK: tick_tone();
            OP_PLAY_NOW: begin
                if (beeper_mode_q != MODE_QUIET) begin
                    tone_freq_m  = pitched_freq(it.freq);
                    time_left_m  = scaled_len(it.length);
                    pause_left_m = it.pause;
                    tone_step_m  = it.freq_step;
                    count_m      = 0;
                    if (it.rpt != 8'd0)
                        void'(queue_tone(it, it.rpt - 8'd1));
                end
            end
            OP_PLAY_QUEUED: begin
                if (beeper_mode_q != MODE_QUIET)
                    dropped = queue_tone(it, it.rpt);
            end
            default: ;
        endcase
        st.speaker = speaker_m;
        st.busy    = (time_left_m != 8'd0);
        st.freq    = tone_freq_m;
        st.dropped = dropped;
        expected_status.push_back(st);
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    t_tone_status got_status;
    t_tone_status want_status;

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status.speaker = m_axis_tdata[0];
            got_status.busy    = m_axis_tdata[1];
            got_status.freq    = m_axis_tdata[9:2];
            got_status.dropped = m_axis_tdata[10];
            if (expected_status.size() == 0) begin
                log_failure($sformatf("unexpected result beat at %0t", $realtime));
            end else begin
                want_status = expected_status.pop_front();
                if (got_status.speaker !== want_status.speaker ||
                    got_status.busy    !== want_status.busy    ||
                    got_status.freq    !== want_status.freq    ||
                    got_status.dropped !== want_status.dropped) begin
                    log_failure({$sformatf("mismatch at %0t: expected ", $realtime),
                                 $sformatf("spk=%0b busy=%0b freq=%0d drop=%0b",
                                           want_status.speaker, want_status.busy,
                                           want_status.freq, want_status.dropped),
                                 $sformatf(", got spk=%0b busy=%0b freq=%0d drop=%0b",
                                           got_status.speaker, got_status.busy,
                                           got_status.freq, got_status.dropped)});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(input logic [1:0] op, input logic [7:0] freq,
                                           input logic [7:0] len, input logic [7:0] pause,
                                           input logic [7:0] rpt, input logic [7:0] step);
        t_in_item it;
        it.op        = op;
        it.freq      = freq;
        it.length    = len;
        it.pause     = pause;
        it.rpt       = rpt;
        it.freq_step = step;
        return it;
    endfunction

    // mostly ticks so the tones actually advance; short tones keep the queue moving
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            it.op = OP_TICK;
        else if (pick < 91)
            it.op = OP_PLAY_NOW;
        else if (pick < 98)
            it.op = OP_PLAY_QUEUED;
        else
            it.op = OP_UNUSED;
        it.freq      = 8'($urandom);
        it.freq_step = 8'($urandom);
        it.length    = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        it.pause     = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        it.rpt       = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        return it;
    endfunction

    task automatic send_beat(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.freq_step, it.rpt, it.pause, it.length, it.freq};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_beat(it);
    endtask

    // drain every result, then give the block its pipeline time
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle_block();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_BEEPER_MODE)
            beeper_mode_q = val[2:0];
        else
            speaker_pitch_q = val;
    endtask

    task automatic set_mode(input logic [2:0] mode);
        write_reg(REG_BEEPER_MODE, {5'd0, mode});
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_field_extremes();
        send_beat(make_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_beat(make_item(OP_PLAY_NOW, 8'hff, 8'hff, 8'hff, 8'h00, 8'h80));
        send_beat(make_item(OP_PLAY_QUEUED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7f));
        send_beat(make_item(OP_PLAY_QUEUED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_beat(make_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(make_item(OP_TICK, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        // play now flushes and queues 254 repeats
        send_beat(make_item(OP_PLAY_NOW, 8'h40, 8'h01, 8'h00, 8'hff, 8'h7f));
        send_beat(make_item(OP_PLAY_NOW, 8'h10, 8'h00, 8'h02, 8'h01, 8'h01));
    endtask

    task automatic test_length_scaling();
        write_reg(REG_SPEAKER_PITCH, 8'hff);
        set_mode(MODE_SEVEN);
        send_beat(make_item(OP_PLAY_NOW, 8'hff, 8'd200, 8'd3, 8'd0, 8'h01));
        send_beat(make_item(OP_PLAY_QUEUED, 8'd246, 8'hff, 8'd0, 8'd0, 8'h00));
        set_mode(MODE_XLONG);
        send_beat(make_item(OP_PLAY_QUEUED, 8'd1, 8'hff, 8'd1, 8'd1, 8'hfe));
        set_mode(MODE_ONE_HALF);
        send_beat(make_item(OP_PLAY_NOW, 8'd20, 8'hff, 8'd0, 8'd2, 8'h02));
        set_mode(MODE_SHORT);
        send_beat(make_item(OP_PLAY_QUEUED, 8'd30, 8'hff, 8'd0, 8'd0, 8'h03));
        set_mode(MODE_LONG);
        send_beat(make_item(OP_PLAY_NOW, 8'd40, 8'd200, 8'd0, 8'd0, 8'h04));
    endtask

    task automatic test_quiet_mode();
        set_mode(MODE_QUIET);
        send_beat(make_item(OP_PLAY_NOW, 8'd90, 8'd5, 8'd1, 8'd3, 8'h05));
        send_beat(make_item(OP_PLAY_QUEUED, 8'd91, 8'd6, 8'd2, 8'd1, 8'hf0));
        send_beat(make_item(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_full_queue();
        int n;
        set_mode(MODE_NORMAL);
        send_beat(make_item(OP_PLAY_NOW, 8'd50, 8'd2, 8'd0, 8'd0, 8'h00));
        // the ninth request finds no room
        for (n = 0; n <= QUEUE_DEPTH; n++)
            send_beat(make_item(OP_PLAY_QUEUED, 8'($urandom), 8'($urandom_range(0, 2)),
                                8'd0, 8'd0, 8'($urandom)));
        send_beat(make_item(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    task automatic test_random_traffic(input logic [2:0] mode, input logic [7:0] pitch,
                                       input int count);
        int n;
        set_mode(mode);
        write_reg(REG_SPEAKER_PITCH, pitch);
        for (n = 0; n < count; n++)
            send_beat(random_item());
    endtask

    // receiver holds off while items keep coming, so s_axis_tready must drop
    task automatic test_output_stall();
        int n;
        settle_block();
        stall_request = 120;
        for (n = 0; n < 30; n++)
            send_beat(random_item());
    endtask

    initial begin
        reset_sequencer();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 28;
        recv_idle_pct = 70;
        test_field_extremes();
        test_length_scaling();
        test_quiet_mode();
        test_full_queue();
        test_random_traffic(MODE_SHORT, 8'd0, 160);
        test_random_traffic(MODE_XLONG, 8'hff, 160);

        send_idle_pct = 70;
        recv_idle_pct = 28;
        test_random_traffic(MODE_SEVEN, 8'd128, 160);
        test_random_traffic(MODE_ONE_HALF, 8'd77, 160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(MODE_LONG, 8'd1, 160);
        test_output_stall();
        test_random_traffic(MODE_NO_KEYS, 8'd200, 160);
        test_random_traffic(MODE_NORMAL, 8'd10, 160);

        settle_block();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
